FILE: rtl/cdc_pkg.sv
// Package: constants, types and tables for the civil date / day count converter.
package cdc_pkg;

  // Accepted year range
  localparam int unsigned YEAR_FIRST = 1970;
  localparam int unsigned YEAR_LAST  = 9999;
  localparam logic [13:0] YEAR_MIN = 14'((YEAR_FIRST < 1970) ? 1970 : YEAR_FIRST);
  localparam logic [13:0] YEAR_MAX = 14'(YEAR_LAST);

  // Day counts of the calendar cycles, counted from 0000-03-01
  localparam logic [22:0] EPOCH_SHIFT = 23'd719468;
  localparam logic [17:0] ERA_DAYS    = 18'(365 * 400 + 97);
  localparam logic [15:0] CENT_DAYS   = 16'(365 * 100 + 24);
  localparam logic [10:0] QUAD_DAYS   = 11'(365 * 4 + 1);
  localparam logic [8:0]  YEAR_DAYS   = 9'd365;

  // Reciprocals for division by constants
  localparam int unsigned ERA_SHIFT  = 41;
  localparam logic [23:0] ERA_RECIP  = 24'((64'd1 << ERA_SHIFT) / 64'(ERA_DAYS));
  localparam int unsigned QUAD_SHIFT = 32;
  localparam logic [21:0] QUAD_RECIP = 22'((64'd1 << QUAD_SHIFT) / 64'(QUAD_DAYS));
  localparam int unsigned WEEK_SHIFT = 32;
  localparam logic [29:0] WEEK_RECIP = 30'((64'd1 << WEEK_SHIFT) / 64'd7);
  // Rounded-up reciprocal, exact for every 14-bit numerator
  localparam int unsigned HUND_SHIFT = 20;
  localparam logic [13:0] HUND_RECIP = 14'(((64'd1 << HUND_SHIFT) + 64'd99) / 64'd100);

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_YEAR  = 3'd1,
    ERR_MONTH = 3'd2,
    ERR_DAY   = 3'd3,
    ERR_COUNT = 3'd4
  } err_e;

  // Working word carried down the pipeline
  typedef struct packed {
    logic        mode;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [21:0] cnt;
    err_e        err;
    logic [13:0] sy;     // March-based year
    logic [3:0]  sm;     // March-based month index
    logic [7:0]  q100y;  // year / 100
    logic [7:0]  q100s;  // sy / 100
    logic [22:0] part;   // day count of whole years
    logic [22:0] z;      // count shifted to 0000-03-01
    logic [5:0]  era;
    logic [18:0] rem;
    logic [1:0]  cent;
    logic [4:0]  quad;
    logic [20:0] wq;     // (cnt + 4) / 7 estimate
    logic [2:0]  wd;
  } pipe_t;

  // Length of a month, 1..12
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Days before March-based month mi: (153 * mi + 2) / 5
  function automatic logic [8:0] month_offset(input logic [3:0] mi);
    logic [8:0] off;
    case (mi)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd31;
      4'd2:    off = 9'd61;
      4'd3:    off = 9'd92;
      4'd4:    off = 9'd122;
      4'd5:    off = 9'd153;
      4'd6:    off = 9'd184;
      4'd7:    off = 9'd214;
      4'd8:    off = 9'd245;
      4'd9:    off = 9'd275;
      4'd10:   off = 9'd306;
      4'd11:   off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

FILE: rtl/civil_date_day_count_converter.sv
// Top level: pipelined Gregorian date <-> day count converter.
//
//  channel | handshake                 | word
//  --------+---------------------------+----------------------------------------------
//  input   | in_valid_i / in_ready_o   | mode, in_day, in_month, in_year, in_day_count
//  output  | out_valid_o / out_ready_i | out_day_count, out_day, out_month, out_year,
//          |                           | weekday, error_code
//
// Eleven register stages; one word can enter every cycle unless out_ready_i is low and
// every stage is full. The longest stage is a reciprocal multiply (23 x 30 bits).
// Each stage loads when it is empty or the stage after it loads, so bubbles collapse
// and the input keeps taking words while a result waits at the output, until every
// stage is full. Reset clears the stage valid bits only.
module civil_date_day_count_converter
  import cdc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [4:0]  in_day_i,
  input  logic [3:0]  in_month_i,
  input  logic [13:0] in_year_i,
  input  logic [21:0] in_day_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [21:0] out_day_count_o,
  output logic [4:0]  out_day_o,
  output logic [3:0]  out_month_o,
  output logic [13:0] out_year_o,
  output logic [2:0]  weekday_o,
  output logic [2:0]  error_code_o
);

  localparam int NUM_STAGES = 11;
  localparam int LAST = NUM_STAGES - 1;

  pipe_t st_q [NUM_STAGES];
  pipe_t st_d [NUM_STAGES];
  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] en;

  // Stage enables: load when empty or when the next stage loads
  always_comb begin
    en[LAST] = !valid_q[LAST] || out_ready_i;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // S0: capture, year and month checks, March-based year; shift count to 0000-03-01
  always_comb begin
    st_d[0]       = '0;
    st_d[0].mode  = mode_i;
    st_d[0].day   = in_day_i;
    st_d[0].month = in_month_i;
    st_d[0].year  = in_year_i;
    st_d[0].cnt   = in_day_count_i;
    st_d[0].err   = ERR_NONE;
    if (!mode_i) begin
      if (in_year_i < YEAR_MIN || in_year_i > YEAR_MAX) begin
        st_d[0].err = ERR_YEAR;
      end else if (in_month_i == 4'd0 || in_month_i > 4'd12) begin
        st_d[0].err = ERR_MONTH;
      end
    end
    st_d[0].sy = (in_month_i <= 4'd2) ? in_year_i - 14'd1 : in_year_i;
    st_d[0].sm = (in_month_i > 4'd2) ? in_month_i - 4'd3 : in_month_i + 4'd9;
    st_d[0].z  = {1'b0, in_day_count_i} + EPOCH_SHIFT;
  end

  // S1: year / 100, sy / 100, era estimate
  always_comb begin
    logic [27:0] prod_y;
    logic [27:0] prod_s;
    logic [46:0] prod_e;
    st_d[1]       = st_q[0];
    prod_y        = st_q[0].year * HUND_RECIP;
    prod_s        = st_q[0].sy * HUND_RECIP;
    prod_e        = st_q[0].z * ERA_RECIP;
    st_d[1].q100y = 8'(prod_y >> HUND_SHIFT);
    st_d[1].q100s = 8'(prod_s >> HUND_SHIFT);
    st_d[1].era   = 6'(prod_e >> ERA_SHIFT);
  end

  // S2: leap rule, day check, whole-year days; era remainder
  always_comb begin
    logic [14:0] hund_y;
    logic        y_div100;
    logic        leap;
    logic [4:0]  mlen;
    logic [22:0] era_days;
    st_d[2]  = st_q[1];
    hund_y   = 15'(st_q[1].q100y) * 15'd100;
    y_div100 = (hund_y == {1'b0, st_q[1].year});
    leap     = (st_q[1].year[1:0] == 2'b00 && !y_div100) ||
               (y_div100 && st_q[1].q100y[1:0] == 2'b00);
    mlen     = month_len(st_q[1].month, leap);
    if (!st_q[1].mode && st_q[1].err == ERR_NONE &&
        (st_q[1].day == 5'd0 || st_q[1].day > mlen)) begin
      st_d[2].err = ERR_DAY;
    end
    st_d[2].part = 23'(st_q[1].sy) * 23'(YEAR_DAYS) + 23'(st_q[1].sy[13:2])
                 - 23'(st_q[1].q100s) + 23'(st_q[1].q100s[7:2]);
    era_days     = 23'(st_q[1].era) * 23'(ERA_DAYS);
    st_d[2].rem  = 19'(st_q[1].z - era_days);
  end

  // S3: final day count for dates; era correction for counts
  always_comb begin
    st_d[3] = st_q[2];
    if (!st_q[2].mode) begin
      st_d[3].cnt = 22'(st_q[2].part + 23'(month_offset(st_q[2].sm))
                        + 23'(st_q[2].day) - 23'd1 - EPOCH_SHIFT);
    end
    if (st_q[2].rem >= 19'(ERA_DAYS)) begin
      st_d[3].era = st_q[2].era + 6'd1;
      st_d[3].rem = st_q[2].rem - 19'(ERA_DAYS);
    end
  end

  // S4: weekday quotient estimate; century within era
  always_comb begin
    logic [22:0] x;
    logic [52:0] prod_w;
    logic [19:0] t;
    logic [1:0]  cent;
    logic [18:0] cent_days;
    st_d[4]    = st_q[3];
    x          = 23'(st_q[3].cnt) + 23'd4;
    prod_w     = x * WEEK_RECIP;
    st_d[4].wq = 21'(prod_w >> WEEK_SHIFT);
    t          = {st_q[3].rem[17:0], 2'b11};
    if (t >= 20'(3 * ERA_DAYS)) begin
      cent = 2'd3;
    end else if (t >= 20'(2 * ERA_DAYS)) begin
      cent = 2'd2;
    end else if (t >= 20'(ERA_DAYS)) begin
      cent = 2'd1;
    end else begin
      cent = 2'd0;
    end
    cent_days    = 19'(cent) * 19'(CENT_DAYS);
    st_d[4].cent = cent;
    st_d[4].rem  = st_q[3].rem - cent_days;
  end

  // S5: weekday remainder; 4-year cycle estimate
  always_comb begin
    logic [3:0]  r;
    logic [36:0] prod_q;
    st_d[5]      = st_q[4];
    r            = st_q[4].cnt[3:0] + 4'd4 - 4'(st_q[4].wq[3:0] * 4'd7);
    st_d[5].wd   = (r >= 4'd7) ? 3'(r - 4'd7) : r[2:0];
    prod_q       = 37'(st_q[4].rem[15:0]) * 37'(QUAD_RECIP);
    st_d[5].quad = 5'(prod_q >> QUAD_SHIFT);
  end

  // S6: 4-year cycle remainder
  always_comb begin
    logic [18:0] quad_days;
    st_d[6]     = st_q[5];
    quad_days   = 19'(st_q[5].quad) * 19'(QUAD_DAYS);
    st_d[6].rem = st_q[5].rem - quad_days;
  end

  // S7: 4-year cycle correction
  always_comb begin
    st_d[7] = st_q[6];
    if (st_q[6].rem >= 19'(QUAD_DAYS)) begin
      st_d[7].quad = st_q[6].quad + 5'd1;
      st_d[7].rem  = st_q[6].rem - 19'(QUAD_DAYS);
    end
  end

  // S8: year within cycle (last one absorbs the leap day), March-based year
  always_comb begin
    logic [1:0] yic;
    st_d[8] = st_q[7];
    if (st_q[7].rem >= 19'(3 * YEAR_DAYS)) begin
      yic = 2'd3;
    end else if (st_q[7].rem >= 19'(2 * YEAR_DAYS)) begin
      yic = 2'd2;
    end else if (st_q[7].rem >= 19'(YEAR_DAYS)) begin
      yic = 2'd1;
    end else begin
      yic = 2'd0;
    end
    st_d[8].rem = st_q[7].rem - 19'(yic) * 19'(YEAR_DAYS);
    st_d[8].sy  = 14'(st_q[7].era) * 14'd400 + 14'(st_q[7].cent) * 14'd100
                + {7'd0, st_q[7].quad, 2'b00} + 14'(yic);
  end

  // S9: month and day from day of March-based year
  always_comb begin
    logic [3:0] mi;
    logic [8:0] doy;
    st_d[9] = st_q[8];
    doy     = st_q[8].rem[8:0];
    mi      = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (doy >= month_offset(4'(k))) begin
        mi = 4'(k);
      end
    end
    if (st_q[8].mode) begin
      st_d[9].day   = 5'(doy - month_offset(mi) + 9'd1);
      st_d[9].month = (mi < 4'd10) ? mi + 4'd3 : mi - 4'd9;
      st_d[9].year  = st_q[8].sy + ((mi >= 4'd10) ? 14'd1 : 14'd0);
    end
  end

  // S10: count range check, clear fields on error
  always_comb begin
    st_d[10] = st_q[9];
    if (st_q[9].mode && (st_q[9].year < YEAR_MIN || st_q[9].year > YEAR_MAX)) begin
      st_d[10].err = ERR_COUNT;
    end
    if (st_d[10].err != ERR_NONE) begin
      st_d[10].cnt   = '0;
      st_d[10].day   = '0;
      st_d[10].month = '0;
      st_d[10].year  = '0;
      st_d[10].wd    = '0;
    end
  end

  // Output word
  assign out_valid_o     = valid_q[LAST];
  assign out_day_count_o = st_q[LAST].cnt;
  assign out_day_o       = st_q[LAST].day;
  assign out_month_o     = st_q[LAST].month;
  assign out_year_o      = st_q[LAST].year;
  assign weekday_o       = st_q[LAST].wd;
  assign error_code_o    = st_q[LAST].err;

endmodule
